/* src/counting_key_stack_top_assert.svh */
// ----------------------------------------------------------------------------
// counting_key_stack_top_assert.svh
// Assertion macros for the counting key stack checker.
// ----------------------------------------------------------------------------
`ifndef COUNTING_KEY_STACK_TOP_ASSERT_SVH
`define COUNTING_KEY_STACK_TOP_ASSERT_SVH

// Clocked assertion, muted during reset.
`define CKSTK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define CKSTK_ASSERT_NEXT(label, ante, cons, msg) \
  `CKSTK_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* src/ckstk_pkg.sv */
// ----------------------------------------------------------------------------
// ckstk_pkg
// Types and codes for the counting key stack.
// ----------------------------------------------------------------------------
package ckstk_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 32;
  localparam int OCC_W = 7;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_FIND,
    ST_UPD,
    ST_RPT
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic             cmp;
    logic             inc;
    logic             load;
    logic             shift;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* src/ckstk_cell.sv */
// ----------------------------------------------------------------------------
// ckstk_cell
// One stack slot: key, count, compare flag; shifts down from its upper neighbor.
// ----------------------------------------------------------------------------
module ckstk_cell #(
  parameter int DEPTH = 64,
  parameter int IDX = 0,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  ckstk_pkg::cell_ctrl_t          ctrl,
  input  logic [CW-1:0]                  used,
  input  logic [IW-1:0]                  slot,
  input  logic [ckstk_pkg::KEY_W-1:0]    up_key,
  input  logic [ckstk_pkg::CNT_W-1:0]    up_count,
  output logic [ckstk_pkg::KEY_W-1:0]    key_q,
  output logic [ckstk_pkg::CNT_W-1:0]    count_q,
  output logic                           match
);

  logic occupied;
  logic is_free_slot;
  logic at_or_above;

  assign occupied     = CW'(IDX) < used;
  assign is_free_slot = CW'(IDX) == used;
  assign at_or_above  = IW'(IDX) >= slot;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match <= occupied && (key_q == ctrl.key);
    end
    if (ctrl.load && is_free_slot) begin
      key_q   <= ctrl.key;
      count_q <= ckstk_pkg::CNT_W'(1);
    end else if (ctrl.inc && match) begin
      if (count_q != '1) begin
        count_q <= count_q + ckstk_pkg::CNT_W'(1);
      end
    end else if (ctrl.shift && at_or_above) begin
      key_q   <= up_key;
      count_q <= up_count;
    end
  end

endmodule

/* src/ckstk_sel.sv */
// ----------------------------------------------------------------------------
// ckstk_sel
// One-hot AND-OR select across the cell row.
// ----------------------------------------------------------------------------
module ckstk_sel #(
  parameter int N = 64,
  parameter int W = 32
) (
  input  logic [N-1:0] sel,
  input  logic [W-1:0] data [N],
  output logic [W-1:0] q
);

  always_comb begin
    q = '0;
    for (int i = 0; i < N; i++) begin
      q = q | (data[i] & {W{sel[i]}});
    end
  end

endmodule

/* src/counting_key_stack_top.sv */
// ----------------------------------------------------------------------------
// counting_key_stack_top
// Stack of distinct keys with hit counts, held in a row of compare cells.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              word
//   cmd       in          cmd_valid / cmd_stall  command, key
//   rsp       out         rsp_valid / rsp_stall  status, out_key, out_count,
//                                                top_valid, top_key, top_count,
//                                                occupancy
//
// Each word passes through accept, parallel compare in every cell, one-hot
// resolve of the hit, cell update (increment, load, or shift down), and report.
// A new word is taken while a result still sits in the output register;
// the report step waits only when that register is still full and stalled.
// Reset clears the entry count and the handshakes; cell contents are
// undefined until written.
// ----------------------------------------------------------------------------
module counting_key_stack_top #(
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [1:0]                         command,
  input  logic signed [ckstk_pkg::KEY_W-1:0] key,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [1:0]                         status,
  output logic signed [ckstk_pkg::KEY_W-1:0] out_key,
  output logic [ckstk_pkg::CNT_W-1:0]        out_count,
  output logic                               top_valid,
  output logic signed [ckstk_pkg::KEY_W-1:0] top_key,
  output logic [ckstk_pkg::CNT_W-1:0]        top_count,
  output logic [ckstk_pkg::OCC_W-1:0]        occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int KW = ckstk_pkg::KEY_W;
  localparam int NW = ckstk_pkg::CNT_W;

  ckstk_pkg::state_t     state, state_next;
  ckstk_pkg::cell_ctrl_t ctrl;

  ckstk_pkg::cmd_t    cmd;
  logic [KW-1:0]      key_r;
  logic [CW-1:0]      used;
  logic               found;
  logic [NW-1:0]      fcount;
  logic [IW-1:0]      slot;
  logic [KW-1:0]      pk;
  logic [NW-1:0]      pc;
  ckstk_pkg::status_t res_status;
  logic [KW-1:0]      res_key;
  logic [NW-1:0]      res_count;
  ckstk_pkg::status_t res_status_next;
  logic [KW-1:0]      res_key_next;
  logic [NW-1:0]      res_count_next;

  logic               accept;
  logic               rpt_load;
  logic               full;

  logic [KW-1:0]      cell_key   [DEPTH];
  logic [NW-1:0]      cell_count [DEPTH];
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   top_hot;
  logic [KW+NW-1:0]   top_data   [DEPTH];
  logic [KW+NW-1:0]   top_pair;
  logic [NW-1:0]      hit_count;
  logic [IW-1:0]      hit_slot;

  assign full   = used == CW'(DEPTH);
  assign accept = cmd_valid && !cmd_stall;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KW-1:0] up_k;
    logic [NW-1:0] up_c;
    if (g == DEPTH - 1) begin : g_last
      assign up_k = cell_key[g];
      assign up_c = cell_count[g];
    end else begin : g_mid
      assign up_k = cell_key[g+1];
      assign up_c = cell_count[g+1];
    end

    ckstk_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .used     (used),
      .slot     (slot),
      .up_key   (up_k),
      .up_count (up_c),
      .key_q    (cell_key[g]),
      .count_q  (cell_count[g]),
      .match    (match[g])
    );

    assign top_hot[g]  = (used != '0) && (CW'(g + 1) == used);
    assign top_data[g] = {cell_key[g], cell_count[g]};
  end

  ckstk_sel #(
    .N (DEPTH),
    .W (NW)
  ) u_hit_sel (
    .sel  (match),
    .data (cell_count),
    .q    (hit_count)
  );

  ckstk_sel #(
    .N (DEPTH),
    .W (KW + NW)
  ) u_top_sel (
    .sel  (top_hot),
    .data (top_data),
    .q    (top_pair)
  );

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        hit_slot = hit_slot | IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckstk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    rpt_load   = 1'b0;
    ctrl       = '0;
    ctrl.key   = key_r;
    case (state)
      ckstk_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          state_next = ckstk_pkg::ST_CMP;
        end
      end
      ckstk_pkg::ST_CMP: begin
        ctrl.cmp   = 1'b1;
        state_next = ckstk_pkg::ST_FIND;
      end
      ckstk_pkg::ST_FIND: begin
        state_next = ckstk_pkg::ST_UPD;
      end
      ckstk_pkg::ST_UPD: begin
        ctrl.inc   = (cmd == ckstk_pkg::CMD_PUSH) && found;
        ctrl.load  = (cmd == ckstk_pkg::CMD_PUSH) && !found && !full;
        ctrl.shift = (cmd == ckstk_pkg::CMD_DELETE) && found;
        state_next = ckstk_pkg::ST_RPT;
      end
      ckstk_pkg::ST_RPT: begin
        if (!(rsp_valid && rsp_stall)) begin
          rpt_load   = 1'b1;
          state_next = ckstk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ckstk_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_status_next = ckstk_pkg::STAT_OK;
    res_key_next    = key_r;
    res_count_next  = fcount;
    case (cmd)
      ckstk_pkg::CMD_PUSH: begin
        if (found) begin
          res_count_next = (fcount != '1) ? fcount + NW'(1) : fcount;
        end else if (!full) begin
          res_count_next = NW'(1);
        end else begin
          res_status_next = ckstk_pkg::STAT_FULL;
          res_count_next  = '0;
        end
      end
      ckstk_pkg::CMD_POP: begin
        if (used == '0) begin
          res_status_next = ckstk_pkg::STAT_EMPTY;
          res_key_next    = '0;
          res_count_next  = '0;
        end else begin
          res_key_next   = pk;
          res_count_next = pc;
        end
      end
      ckstk_pkg::CMD_SEARCH, ckstk_pkg::CMD_DELETE: begin
        if (!found) begin
          res_status_next = ckstk_pkg::STAT_NOT_FOUND;
          res_count_next  = '0;
        end
      end
      default: begin
        res_status_next = ckstk_pkg::STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= ckstk_pkg::cmd_t'(command);
      key_r <= key;
    end
    if (state == ckstk_pkg::ST_FIND) begin
      found  <= |match;
      fcount <= hit_count;
      slot   <= hit_slot;
      pk     <= top_pair[KW+NW-1:NW];
      pc     <= top_pair[NW-1:0];
    end
    if (state == ckstk_pkg::ST_UPD) begin
      res_status <= res_status_next;
      res_key    <= res_key_next;
      res_count  <= res_count_next;
    end
    if (rpt_load) begin
      status    <= res_status;
      out_key   <= res_key;
      out_count <= res_count;
      top_valid <= used != '0;
      top_key   <= top_pair[KW+NW-1:NW];
      top_count <= top_pair[NW-1:0];
      occupancy <= ckstk_pkg::OCC_W'(used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ckstk_pkg::ST_UPD) begin
        if (ctrl.load) begin
          used <= used + CW'(1);
        end else if (ctrl.shift || (cmd == ckstk_pkg::CMD_POP && used != '0)) begin
          used <= used - CW'(1);
        end
      end
      if (rpt_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/ckstk_checker.sv */
// ----------------------------------------------------------------------------
// ckstk_checker
// Port-level checks for the counting key stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "counting_key_stack_top_assert.svh"

module ckstk_checker #(
  parameter int DEPTH = 64
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_stall,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic [1:0]                         status,
  input logic signed [ckstk_pkg::KEY_W-1:0] out_key,
  input logic [ckstk_pkg::CNT_W-1:0]        out_count,
  input logic                               top_valid,
  input logic signed [ckstk_pkg::KEY_W-1:0] top_key,
  input logic [ckstk_pkg::CNT_W-1:0]        top_count,
  input logic [ckstk_pkg::OCC_W-1:0]        occupancy
);

  logic top_clear;
  logic full_word;
  logic empty_word;
  logic full_ok;
  logic empty_ok;

  assign top_clear  = occupancy == '0 && top_key == '0 && top_count == '0;
  assign full_word  = rsp_valid && status == ckstk_pkg::STAT_FULL;
  assign empty_word = rsp_valid && status == ckstk_pkg::STAT_EMPTY;
  assign full_ok    = out_count == '0 && top_valid &&
                      occupancy == ckstk_pkg::OCC_W'(DEPTH);
  assign empty_ok   = out_key == '0 && out_count == '0 && !top_valid && occupancy == '0;

  `CKSTK_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "cmd taken while busy")
  `CKSTK_ASSERT(a_empty_top, rsp_valid && !top_valid |-> top_clear, "empty stack shows a top word")
  `CKSTK_ASSERT(a_full_status, full_word |-> full_ok, "full status with bad fields")
  `CKSTK_ASSERT(a_empty_status, empty_word |-> empty_ok, "empty status with bad fields")
  `CKSTK_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable({status, out_key, out_count}), "stalled rsp word changed")

endmodule

bind counting_key_stack_top ckstk_checker #(.DEPTH(DEPTH)) u_ckstk_checker (.*);
